// File: design/mrre_pkg.sv
// Shared types and constants for the mask row run extractor.
package mrre_pkg;

  // Largest mask dimension the coordinate fields can carry
  localparam int unsigned MaxDim = 4096;
  // Default cap on instance numbers within one image
  localparam int unsigned MaxInstancesDefault = 256;
  // Result queue depth (power of two)
  localparam int unsigned ResDepth = 4;

  // Field widths
  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned IdW    = 9;
  localparam int unsigned CountW = 16;
  localparam int unsigned LabelW = 32;
  localparam int unsigned PixelW = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_MASK_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MASK_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAX_BOXES   = 2'd2;

  // Result kinds
  localparam logic RES_BOX   = 1'b0;
  localparam logic RES_COUNT = 1'b1;

  // One result beat
  typedef struct packed {
    logic                     result_type;
    logic [CoordW-1:0]        row;
    logic [CoordW-1:0]        col_start;
    logic [DimW-1:0]          col_end;
    logic signed [LabelW-1:0] box_label;
    logic [IdW-1:0]           instance_id;
    logic [CountW-1:0]        box_count;
    logic                     overflow;
    logic                     last;
  } res_t;

endpackage

// File: design/mask_row_run_extractor.sv
// Top level: per-pixel run tracking of instance masks with a result queue.
// Each result is registered in the result queue before it reaches the master side.
// Throughput: one pixel per cycle; the 4-entry result queue absorbs the pixel that
// gives both a box and the image count, and tready drops while it holds over two.
// Reset clears column, row, run, instance and box counters; width and height
// reset to 1 and the box cap to 0 (no cap below the counter limit).
module mask_row_run_extractor #(
  parameter int unsigned MAX_INSTANCES = mrre_pkg::MaxInstancesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Pixel stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pixel[7:0], label[39:8]
  input  logic        s_axis_tuser,   // last_instance
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // row, col_start, col_end, box_label,
                                      // instance_id, box_count, overflow, pad
  output logic        m_axis_tuser,   // result_type
  output logic        m_axis_tlast    // last
);

  localparam int unsigned CoordW = mrre_pkg::CoordW;
  localparam int unsigned DimW   = mrre_pkg::DimW;
  localparam int unsigned CountW = mrre_pkg::CountW;
  localparam int unsigned IdW    = mrre_pkg::IdW;
  localparam int unsigned InstW  = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int unsigned LvlW   = $clog2(mrre_pkg::ResDepth + 1);

  // Configuration registers
  logic [DimW-1:0]   mask_width_q, mask_height_q;
  logic [CountW-1:0] max_boxes_q;

  // Tracking state
  logic [CoordW-1:0] column_q, column_d;
  logic [CoordW-1:0] row_q, row_d;
  logic              run_open_q, run_open_d;
  logic [CoordW-1:0] run_begin_q, run_begin_d;
  logic [InstW-1:0]  inst_q, inst_d;
  logic [CountW-1:0] boxes_q, boxes_d;
  logic              dropped_q, dropped_d;

  // Per-pixel decode
  logic                     in_fire, fg, last_inst;
  logic signed [31:0]       label;
  logic [DimW-1:0]          w_eff, h_eff;
  logic [CountW-1:0]        cap;
  logic                     row_end, mask_end;
  logic                     close_mid, close_end, close_any;
  logic                     emit, drop, count_res;
  logic [CoordW-1:0]        begin_col;
  logic [DimW-1:0]          end_col;
  mrre_pkg::res_t           box_res, cnt_res, push0, push1, head;
  logic [1:0]               push_cnt;
  logic                     q_space;
  logic [LvlW-1:0]          q_level;

  assign cfg_ready_o = 1'b1;

  // Capture configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_width_q  <= DimW'(1);
      mask_height_q <= DimW'(1);
      max_boxes_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mrre_pkg::CFG_MASK_WIDTH:  mask_width_q  <= cfg_data_i[DimW-1:0];
        mrre_pkg::CFG_MASK_HEIGHT: mask_height_q <= cfg_data_i[DimW-1:0];
        mrre_pkg::CFG_MAX_BOXES:   max_boxes_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp dimensions into 1..MaxDim and resolve the cap
  always_comb begin
    if (mask_width_q == '0) begin
      w_eff = DimW'(1);
    end else if (mask_width_q > DimW'(mrre_pkg::MaxDim)) begin
      w_eff = DimW'(mrre_pkg::MaxDim);
    end else begin
      w_eff = mask_width_q;
    end
    if (mask_height_q == '0) begin
      h_eff = DimW'(1);
    end else if (mask_height_q > DimW'(mrre_pkg::MaxDim)) begin
      h_eff = DimW'(mrre_pkg::MaxDim);
    end else begin
      h_eff = mask_height_q;
    end
    cap = (max_boxes_q == '0) ? {CountW{1'b1}} : max_boxes_q;
  end

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign fg        = (s_axis_tdata[7:0] != 8'd0);
  assign label     = s_axis_tdata[39:8];
  assign last_inst = s_axis_tuser;

  // Run and position decode
  always_comb begin
    row_end   = ({1'b0, column_q} + DimW'(1)) >= w_eff;
    mask_end  = row_end && (({1'b0, row_q} + DimW'(1)) >= h_eff);
    close_mid = !fg && run_open_q;
    close_end = row_end && fg;
    close_any = close_mid || close_end;
    emit      = close_any && (boxes_q < cap);
    drop      = close_any && !emit;
    count_res = mask_end && last_inst;
    begin_col = (fg && !run_open_q) ? column_q : run_begin_q;
    end_col   = close_mid ? {1'b0, column_q} : w_eff;
  end

  // Next tracking state
  always_comb begin
    boxes_d     = boxes_q + CountW'(emit);
    dropped_d   = dropped_q || drop;
    run_open_d  = fg && !row_end;
    run_begin_d = begin_col;
    column_d    = row_end ? '0 : column_q + CoordW'(1);
    row_d       = row_q;
    inst_d      = inst_q;
    if (row_end) begin
      row_d = mask_end ? '0 : row_q + CoordW'(1);
    end
    if (count_res) begin
      inst_d    = '0;
      boxes_d   = '0;
      dropped_d = 1'b0;
    end else if (mask_end && ((32'(inst_q) + 32'd1) < 32'(MAX_INSTANCES))) begin
      inst_d = inst_q + InstW'(1);
    end
  end

  // Hold tracking state between pixel beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_q       <= '0;
      run_open_q  <= 1'b0;
      run_begin_q <= '0;
      inst_q      <= '0;
      boxes_q     <= '0;
      dropped_q   <= 1'b0;
    end else if (in_fire) begin
      column_q    <= column_d;
      row_q       <= row_d;
      run_open_q  <= run_open_d;
      run_begin_q <= run_begin_d;
      inst_q      <= inst_d;
      boxes_q     <= boxes_d;
      dropped_q   <= dropped_d;
    end
  end

  // Build box and count results, box first
  always_comb begin
    box_res             = '0;
    box_res.result_type = mrre_pkg::RES_BOX;
    box_res.row         = row_q;
    box_res.col_start   = begin_col;
    box_res.col_end     = end_col;
    box_res.box_label   = label;
    box_res.instance_id = IdW'(32'(inst_q) + 32'd1);
    box_res.overflow    = dropped_q;
    box_res.last        = !count_res;

    // Count includes a box emitted on this pixel
    cnt_res             = '0;
    cnt_res.result_type = mrre_pkg::RES_COUNT;
    cnt_res.box_count   = boxes_q + CountW'(emit);
    cnt_res.overflow    = dropped_q || drop;
    cnt_res.last        = 1'b1;

    push0    = emit ? box_res : cnt_res;
    push1    = cnt_res;
    push_cnt = 2'd0;
    if (in_fire) begin
      push_cnt = 2'(emit) + 2'(count_res);
    end
  end

  mrre_res_q u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .pop_i      (m_axis_tready),
    .head_o     (head),
    .valid_o    (m_axis_tvalid),
    .space_o    (q_space),
    .level_o    (q_level)
  );

  assign s_axis_tready = q_space;
  assign m_axis_tuser  = head.result_type;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {1'b0, head.overflow, head.box_count, head.instance_id,
                          head.box_label, head.col_end, head.col_start, head.row};

  // An open run always started left of the current column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> (column_q > run_begin_q))
    else $error("open run does not lie left of the column");

  // The image count clears the per-image counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && count_res) |=> (boxes_q == '0) && !dropped_q && (inst_q == '0))
    else $error("per-image counters not cleared after count result");

  // The result queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= LvlW'(mrre_pkg::ResDepth))
    else $error("result queue overfilled");

endmodule

// File: design/mrre_res_q.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
module mrre_res_q (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic [1:0]                                     push_cnt_i,
  input  mrre_pkg::res_t                                 push0_i,
  input  mrre_pkg::res_t                                 push1_i,
  input  logic                                           pop_i,
  output mrre_pkg::res_t                                 head_o,
  output logic                                           valid_o,
  output logic                                           space_o,
  output logic [$clog2(mrre_pkg::ResDepth + 1)-1:0]      level_o
);

  localparam int unsigned Depth = mrre_pkg::ResDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned LvlW  = $clog2(Depth + 1);

  mrre_pkg::res_t  ent_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr1;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;
  logic            do_pop;

  assign do_pop   = pop_i && (level_q != '0);
  assign wr_ptr1  = wr_ptr_q + PtrW'(1);
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + PtrW'(do_pop);
  assign level_d  = level_q + LvlW'(push_cnt_i) - LvlW'(do_pop);

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Store pushed results in order
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      ent_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      ent_q[wr_ptr1] <= push1_i;
    end
  end

  assign head_o  = ent_q[rd_ptr_q];
  assign valid_o = (level_q != '0);
  assign space_o = (level_q <= LvlW'(Depth - 2));
  assign level_o = level_q;

endmodule
